// ===== src/plt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the tone curve unit
// Level and status widths, command codes, the front-to-back command type.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int LEVEL_W     = 9;
   localparam int STATUS_W    = 2;
   localparam int FULL_SCALE  = 256;
   localparam int PROD_W      = 2 * LEVEL_W;
   localparam int DIV_STEPS   = PROD_W / 2;
   localparam int DCNT_W      = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK             = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL           = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_INCREASING = 2'd2;

   typedef logic [1:0] op_type;
   localparam op_type OP_QUERY       = 2'd0;
   localparam op_type OP_LOAD_FIRST  = 2'd1;
   localparam op_type OP_LOAD_APPEND = 2'd2;

   typedef struct packed {
      op_type             op;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] pout;
   } cmd_type;

endpackage

// ===== src/plt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_front: intake and command queue
// Accepts items, classifies them into commands and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module plt_front import plt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_kind,
   input  logic               req_first_point,
   input  logic [LEVEL_W-1:0] req_level_in,
   input  logic [LEVEL_W-1:0] req_point_out,
   output logic               cmd_valid,
   output cmd_type            cmd,
   input  logic               cmd_pop
);

   cmd_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               push_ok;
   logic               pop_ok;
   cmd_type            new_cmd;

   always_comb begin
      new_cmd.level = req_level_in;
      new_cmd.pout  = req_point_out;
      if (req_kind) begin
         new_cmd.op = OP_QUERY;
      end else if (req_first_point) begin
         new_cmd.op = OP_LOAD_FIRST;
      end else begin
         new_cmd.op = OP_LOAD_APPEND;
      end
   end

   assign req_full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== src/plt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_back: point store, segment search and interpolation
// Executes loads against the point memory; for queries scans the points,
// multiplies and runs a two-bit-per-cycle restoring divide.
// ----------------------------------------------------------------------------
module plt_back import plt_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [LEVEL_W-1:0]  rsp_mapped_level,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);

   localparam logic [2:0] ST_INIT0 = 3'd0;
   localparam logic [2:0] ST_INIT1 = 3'd1;
   localparam logic [2:0] ST_IDLE  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [PROD_W-1:0]   mem [MAX_POINTS];
   logic [PROD_W-1:0]   mem_rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   logic [PROD_W-1:0]   mem_wd;
   logic [IDX_W-1:0]    mem_ra;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [LEVEL_W-1:0]  last_in_ff, last_in_in;
   logic [LEVEL_W-1:0]  x_ff, x_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [LEVEL_W-1:0]  prev_in_ff, prev_in_in;
   logic [LEVEL_W-1:0]  prev_out_ff, prev_out_in;
   logic [LEVEL_W-1:0]  dx_ff, dx_in;
   logic [LEVEL_W-1:0]  den_ff, den_in;
   logic [LEVEL_W-1:0]  dy_mag_ff, dy_mag_in;
   logic                dy_neg_ff, dy_neg_in;
   logic [PROD_W-1:0]   dvd_ff, dvd_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [LEVEL_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0]  out_level_ff, out_level_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic [LEVEL_W-1:0]  rd_in;
   logic [LEVEL_W-1:0]  rd_out;
   logic [CNT_W-1:0]    idx_next;
   logic                is_last;
   logic                start;
   logic [LEVEL_W:0]    r1, r2;
   logic [LEVEL_W-1:0]  rem_a;
   logic                qa, qb;
   logic [LEVEL_W-1:0]  q_mag;

   assign rd_in     = mem_rd_ff[PROD_W-1:LEVEL_W];
   assign rd_out    = mem_rd_ff[LEVEL_W-1:0];
   assign idx_next  = CNT_W'(idx_ff) + 1'b1;
   assign is_last   = (CNT_W'(idx_ff) == count_ff - 1'b1);
   assign start     = (state_ff == ST_IDLE) && cmd_valid && (!out_valid_ff || rsp_pop);
   assign cmd_pop   = start;
   assign q_mag     = quo_ff[LEVEL_W-1:0];

   assign rsp_empty        = !out_valid_ff;
   assign rsp_mapped_level = out_level_ff;
   assign rsp_status       = out_status_ff;

   // two restoring steps per cycle
   always_comb begin
      r1    = {rem_ff, dvd_ff[PROD_W-1]};
      qa    = (r1 >= {1'b0, den_ff});
      rem_a = qa ? LEVEL_W'(r1 - {1'b0, den_ff}) : r1[LEVEL_W-1:0];
      r2    = {rem_a, dvd_ff[PROD_W-2]};
      qb    = (r2 >= {1'b0, den_ff});
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_in_in    = last_in_ff;
      x_in          = x_ff;
      idx_in        = idx_ff;
      prev_in_in    = prev_in_ff;
      prev_out_in   = prev_out_ff;
      dx_in         = dx_ff;
      den_in        = den_ff;
      dy_mag_in     = dy_mag_ff;
      dy_neg_in     = dy_neg_ff;
      dvd_in        = dvd_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_level_in  = out_level_ff;
      out_status_in = out_status_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_ra        = '0;

      case (state_ff)
         ST_INIT0: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = '0;
            state_in = ST_INIT1;
         end
         ST_INIT1: begin
            mem_we   = 1'b1;
            mem_wa   = IDX_W'(1);
            mem_wd   = {LEVEL_W'(FULL_SCALE), LEVEL_W'(FULL_SCALE)};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (cmd.op)
                  OP_QUERY: begin
                     x_in     = cmd.level;
                     idx_in   = '0;
                     mem_ra   = '0;
                     state_in = ST_SCAN;
                  end
                  OP_LOAD_FIRST: begin
                     mem_we        = 1'b1;
                     mem_wa        = '0;
                     mem_wd        = {cmd.level, cmd.pout};
                     count_in      = CNT_W'(1);
                     last_in_in    = cmd.level;
                     out_valid_in  = 1'b1;
                     out_level_in  = '0;
                     out_status_in = STATUS_OK;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     out_level_in = '0;
                     if (count_ff >= CNT_W'(MAX_POINTS)) begin
                        out_status_in = STATUS_FULL;
                     end else if (cmd.level <= last_in_ff) begin
                        out_status_in = STATUS_NOT_INCREASING;
                     end else begin
                        mem_we        = 1'b1;
                        mem_wa        = count_ff[IDX_W-1:0];
                        mem_wd        = {cmd.level, cmd.pout};
                        count_in      = count_ff + 1'b1;
                        last_in_in    = cmd.level;
                        out_status_in = STATUS_OK;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_ra = (idx_next < CNT_W'(MAX_POINTS)) ? idx_next[IDX_W-1:0] : idx_ff;
            if (x_ff < rd_in) begin
               if (idx_ff == '0) begin
                  out_valid_in  = 1'b1;
                  out_level_in  = rd_out;
                  out_status_in = STATUS_OK;
                  state_in      = ST_IDLE;
               end else begin
                  dx_in     = x_ff - prev_in_ff;
                  den_in    = rd_in - prev_in_ff;
                  dy_neg_in = (rd_out < prev_out_ff);
                  dy_mag_in = (rd_out < prev_out_ff) ? prev_out_ff - rd_out
                                                     : rd_out - prev_out_ff;
                  state_in  = ST_MUL;
               end
            end else if (is_last) begin
               out_valid_in  = 1'b1;
               out_level_in  = rd_out;
               out_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end else begin
               prev_in_in  = rd_in;
               prev_out_in = rd_out;
               idx_in      = idx_next[IDX_W-1:0];
            end
         end
         ST_MUL: begin
            dvd_in   = dx_ff * dy_mag_ff;
            quo_in   = '0;
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = qb ? LEVEL_W'(r2 - {1'b0, den_ff}) : r2[LEVEL_W-1:0];
            quo_in  = {quo_ff[PROD_W-3:0], qa, qb};
            dvd_in  = {dvd_ff[PROD_W-3:0], 2'b00};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            out_valid_in  = 1'b1;
            out_level_in  = dy_neg_ff ? prev_out_ff - q_mag : prev_out_ff + q_mag;
            out_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT0;
         count_ff     <= CNT_W'(2);
         last_in_ff   <= LEVEL_W'(FULL_SCALE);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_in_ff   <= last_in_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      idx_ff        <= idx_in;
      prev_in_ff    <= prev_in_in;
      prev_out_ff   <= prev_out_in;
      dx_ff         <= dx_in;
      den_ff        <= den_in;
      dy_mag_ff     <= dy_mag_in;
      dy_neg_ff     <= dy_neg_in;
      dvd_ff        <= dvd_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      out_level_ff  <= out_level_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

endmodule

// ===== src/piecewise_linear_tone_curve_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_tone_curve_unit: tone curve over stored control points
// Request side is a queue: item taken when req_push is high and req_full low.
// kind 0 loads a control point (first_point restarts the list), kind 1 maps
// req_level_in through the polyline. Response side is a queue: the oldest
// item sits on rsp_* while rsp_empty is low and leaves on rsp_pop.
// Every item gives exactly one response item, in order.
// A two-entry command queue sits in front of the executor, and a response
// register behind it, so intake continues while a response waits.
// Loads are done in the idle state. A query scans the point memory one entry
// per cycle, then multiplies, then divides at two quotient bits per divide
// step and finishes. End-of-curve results leave straight from the scan.
// Reset loads the identity curve, writing the two points in ST_INIT0 and
// ST_INIT1; items queue up meanwhile. A stalled response stalls the
// executor; the queue then fills and raises req_full.
// ----------------------------------------------------------------------------
module piecewise_linear_tone_curve_unit import plt_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_kind,
   input  logic                req_first_point,
   input  logic [LEVEL_W-1:0]  req_level_in,
   input  logic [LEVEL_W-1:0]  req_point_out,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [LEVEL_W-1:0]  rsp_mapped_level,
   output logic [STATUS_W-1:0] rsp_status
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   plt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_first_point (req_first_point),
      .req_level_in    (req_level_in),
      .req_point_out   (req_point_out),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   plt_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_mapped_level (rsp_mapped_level),
      .rsp_status       (rsp_status)
   );

   a_rsp_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response present right after reset");

   a_load_level_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> rsp_mapped_level == '0)
      else $error("dropped load carries a nonzero level");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                      rsp_status == STATUS_NOT_INCREASING))
      else $error("undefined status code");

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("executor took a command from an empty queue");

endmodule
